/* hdl/cpt_pkg.sv */
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and constants for the closest point on triangle block
// Coordinate widths, the internal widths that follow from them, the region
// codes and the payload structs that pass between the pipeline sections.
// ----------------------------------------------------------------------------
package cpt_pkg;

   localparam int CW      = 24;               // coordinate bits, signed Q12.12
   localparam int DIFF_W  = CW + 1;           // vertex differences
   localparam int DOT_W   = 2 * DIFF_W + 2;   // dot products
   localparam int HALF_W  = DOT_W / 2;        // split point for dot products
   localparam int PP_W    = 2 * HALF_W + 2;   // partial products of dot products
   localparam int VOL_W   = 2 * DOT_W + 4;    // va, vb, vc and face denominator
   localparam int CHUNK_W = VOL_W / 4;        // split point for numerator products
   localparam int PPN_W   = DIFF_W + CHUNK_W + 1;
   localparam int PAIR_W  = PPN_W + CHUNK_W + 1;
   localparam int NUM_W   = DIFF_W + VOL_W;   // numerators
   localparam int QB      = CW + 2;           // quotient magnitude bits kept
   localparam int REM_W   = VOL_W + QB + 1;   // divider remainder
   localparam int QS_W    = QB + 2;           // signed rounded quotient
   localparam int SUM_W   = QB + 3;           // vertex plus quotient

   typedef logic [2:0] region_type;

   localparam region_type REG_VERT_A  = 3'd0;
   localparam region_type REG_VERT_B  = 3'd1;
   localparam region_type REG_EDGE_AB = 3'd2;
   localparam region_type REG_VERT_C  = 3'd3;
   localparam region_type REG_EDGE_AC = 3'd4;
   localparam region_type REG_EDGE_BC = 3'd5;
   localparam region_type REG_FACE    = 3'd6;

   typedef logic signed [CW-1:0]     coord_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [DOT_W-1:0]  dot_val_type;
   typedef logic signed [VOL_W-1:0]  vol_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      coord_type vert_a_x;
      coord_type vert_a_y;
      coord_type vert_a_z;
      coord_type vert_b_x;
      coord_type vert_b_y;
      coord_type vert_b_z;
      coord_type vert_c_x;
      coord_type vert_c_y;
      coord_type vert_c_z;
   } req_type;

   typedef struct packed {
      coord_type  near_x;
      coord_type  near_y;
      coord_type  near_z;
      region_type region;
      logic       degenerate;
   } rsp_type;

   // vertices and edge vectors, index 0 is x
   typedef struct packed {
      coord_type [2:0] a;
      coord_type [2:0] b;
      coord_type [2:0] c;
      diff_type  [2:0] ab;
      diff_type  [2:0] ac;
      diff_type  [2:0] bc;
   } geo_type;

   // d[0] .. d[5] hold d1 .. d6
   typedef struct packed {
      geo_type            geo;
      dot_val_type [5:0]  d;
   } dot_type;

   // start + (x1*m1 + x2*m2) / den per coordinate
   typedef struct packed {
      coord_type [2:0] start;
      diff_type  [2:0] x1;
      diff_type  [2:0] x2;
      vol_type         m1;
      vol_type         m2;
      vol_type         den;
      logic            div_en;
      region_type      region;
      logic            degen;
   } sel_type;

   typedef struct packed {
      logic [2:0][REM_W-1:0] rem;
      logic [2:0][QB-1:0]    quo;
      logic [VOL_W-1:0]      ud;
      logic [2:0]            neg;
      logic [2:0]            ovf;
      coord_type [2:0]       start;
      logic                  div_en;
      region_type            region;
      logic                  degen;
   } div_type;

   typedef struct packed {
      logic [2:0][QS_W-1:0] quo;
      coord_type [2:0]      start;
      logic                 div_en;
      region_type           region;
      logic                 degen;
   } quo_type;

endpackage

/* hdl/closest_point_on_triangle.sv */
// ----------------------------------------------------------------------------
// closest_point_on_triangle: nearest point of a triangle to a query point
//
//   channel   direction   ports                          payload
//   request   in          req_valid req_ready req_data   query point, A, B, C
//   response  out         rsp_valid rsp_ready rsp_data   near point, region, flag
//
// One transaction enters per cycle unless the pipeline is held; the divider,
// one quotient bit per stage, follows the product and region stages. The
// whole pipeline advances together: it holds while a response is waiting
// and unaccepted, and empty stages travel as bubbles.
// Reset clears only the valid bits; it is synchronous and active high.
// ----------------------------------------------------------------------------
module closest_point_on_triangle (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cpt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cpt_pkg::rsp_type rsp_data
);
   import cpt_pkg::*;

   typedef logic signed [SUM_W-1:0] sum_type;

   localparam sum_type SAT_HI = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam sum_type SAT_LO = ~SAT_HI;

   logic    en;
   logic    dot_valid, sel_valid, abs_valid, quo_valid;
   dot_type dot_data;
   sel_type sel_data;
   div_type abs_data;
   quo_type quo_data;
   rsp_type rsp_in, rsp_ff;
   logic    rsp_valid_ff;

   // advance everything unless a finished response is held
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   cpt_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (dot_valid),
      .out_data  (dot_data)
   );

   cpt_region u_region (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dot_valid),
      .in_data   (dot_data),
      .out_valid (sel_valid),
      .out_data  (sel_data)
   );

   cpt_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sel_valid),
      .in_data   (sel_data),
      .out_valid (abs_valid),
      .out_data  (abs_data)
   );

   cpt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (abs_valid),
      .in_data   (abs_data),
      .out_valid (quo_valid),
      .out_data  (quo_data)
   );

   always_comb begin
      sum_type         sum;
      coord_type [2:0] near;
      for (int k = 0; k < 3; k++) begin
         sum = sum_type'($signed(quo_data.start[k]));
         if (quo_data.div_en) begin
            sum = sum + sum_type'($signed(quo_data.quo[k]));
         end
         if (sum > SAT_HI) begin
            sum = SAT_HI;
         end else if (sum < SAT_LO) begin
            sum = SAT_LO;
         end
         near[k] = sum[CW-1:0];
      end
      rsp_in.near_x     = near[0];
      rsp_in.near_y     = near[1];
      rsp_in.near_z     = near[2];
      rsp_in.region     = quo_data.region;
      rsp_in.degenerate = quo_data.degen;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= quo_valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.degenerate || rsp_data.region == REG_FACE))
      else $error("degenerate flag outside the face region");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.region <= REG_FACE))
      else $error("region code out of range");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while the pipeline is held");
`endif

endmodule

/* hdl/cpt_dot.sv */
// ----------------------------------------------------------------------------
// cpt_dot: edge vectors and the six dot products d1 .. d6
// Three stages: differences, 25x25 products, three-term sums.
// ----------------------------------------------------------------------------
module cpt_dot (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  cpt_pkg::req_type in_data,
   output logic             out_valid,
   output cpt_pkg::dot_type out_data
);
   import cpt_pkg::*;

   typedef logic signed [2*DIFF_W-1:0] prod_type;

   geo_type             geo1_in, geo1_ff, geo2_ff;
   diff_type [2:0]      ap1_in, bp1_in, cp1_in;
   diff_type [2:0]      ap1_ff, bp1_ff, cp1_ff;
   prod_type [5:0][2:0] prod2_in, prod2_ff;
   dot_type             dot3_in, dot3_ff;
   logic                v1_ff, v2_ff, v3_ff;

   always_comb begin
      coord_type [2:0] p, a, b, c;
      p = {in_data.point_z,  in_data.point_y,  in_data.point_x};
      a = {in_data.vert_a_z, in_data.vert_a_y, in_data.vert_a_x};
      b = {in_data.vert_b_z, in_data.vert_b_y, in_data.vert_b_x};
      c = {in_data.vert_c_z, in_data.vert_c_y, in_data.vert_c_x};
      geo1_in.a = a;
      geo1_in.b = b;
      geo1_in.c = c;
      for (int k = 0; k < 3; k++) begin
         geo1_in.ab[k] = diff_type'($signed(b[k])) - diff_type'($signed(a[k]));
         geo1_in.ac[k] = diff_type'($signed(c[k])) - diff_type'($signed(a[k]));
         geo1_in.bc[k] = diff_type'($signed(c[k])) - diff_type'($signed(b[k]));
         ap1_in[k]     = diff_type'($signed(p[k])) - diff_type'($signed(a[k]));
         bp1_in[k]     = diff_type'($signed(p[k])) - diff_type'($signed(b[k]));
         cp1_in[k]     = diff_type'($signed(p[k])) - diff_type'($signed(c[k]));
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod2_in[0][k] = prod_type'($signed(geo1_ff.ab[k])) * prod_type'($signed(ap1_ff[k]));
         prod2_in[1][k] = prod_type'($signed(geo1_ff.ac[k])) * prod_type'($signed(ap1_ff[k]));
         prod2_in[2][k] = prod_type'($signed(geo1_ff.ab[k])) * prod_type'($signed(bp1_ff[k]));
         prod2_in[3][k] = prod_type'($signed(geo1_ff.ac[k])) * prod_type'($signed(bp1_ff[k]));
         prod2_in[4][k] = prod_type'($signed(geo1_ff.ab[k])) * prod_type'($signed(cp1_ff[k]));
         prod2_in[5][k] = prod_type'($signed(geo1_ff.ac[k])) * prod_type'($signed(cp1_ff[k]));
      end
   end

   always_comb begin
      dot3_in.geo = geo2_ff;
      for (int j = 0; j < 6; j++) begin
         dot3_in.d[j] = dot_val_type'($signed(prod2_ff[j][0]))
                      + dot_val_type'($signed(prod2_ff[j][1]))
                      + dot_val_type'($signed(prod2_ff[j][2]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         geo1_ff  <= geo1_in;
         ap1_ff   <= ap1_in;
         bp1_ff   <= bp1_in;
         cp1_ff   <= cp1_in;
         geo2_ff  <= geo1_ff;
         prod2_ff <= prod2_in;
         dot3_ff  <= dot3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = dot3_ff;

endmodule

/* hdl/cpt_region.sv */
// ----------------------------------------------------------------------------
// cpt_region: barycentric volumes, region tests and operand selection
// Five stages: split products of dot products, product sums, va/vb/vc,
// comparisons and denominators, then the priority choice of region.
// ----------------------------------------------------------------------------
module cpt_region (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  cpt_pkg::dot_type in_data,
   output logic             out_valid,
   output cpt_pkg::sel_type out_data
);
   import cpt_pkg::*;

   typedef logic signed [HALF_W:0]  half_type;
   typedef logic signed [PP_W-1:0]  pp_type;
   typedef logic signed [DOT_W+1:0] ed_type;

   dot_type           dot4_ff, dot5_ff, dot6_ff;
   pp_type [5:0][3:0] pp4_in, pp4_ff;
   vol_type [5:0]     prod5_in, prod5_ff;
   vol_type           va6_in, vb6_in, vc6_in, va6_ff, vb6_ff, vc6_ff;
   geo_type           geo7_ff;
   dot_val_type       d1_7_ff, d2_7_ff;
   ed_type            e7_in, e7_ff, dab7_in, dac7_in, dbc7_in, dab7_ff, dac7_ff, dbc7_ff;
   vol_type           vb7_ff, vc7_ff, den7_in, den7_ff;
   logic [5:0]        hit7_in, hit7_ff;
   sel_type           sel8_in, sel8_ff;
   logic              v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;

   function automatic half_type hi_part(input dot_val_type x);
      return half_type'($signed(x[DOT_W-1:HALF_W]));
   endfunction

   function automatic half_type lo_part(input dot_val_type x);
      return half_type'({1'b0, x[HALF_W-1:0]});
   endfunction

   // products: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
   always_comb begin
      dot_val_type [5:0] opa, opb;
      opa[0] = in_data.d[0]; opb[0] = in_data.d[3];
      opa[1] = in_data.d[2]; opb[1] = in_data.d[1];
      opa[2] = in_data.d[4]; opb[2] = in_data.d[1];
      opa[3] = in_data.d[0]; opb[3] = in_data.d[5];
      opa[4] = in_data.d[2]; opb[4] = in_data.d[5];
      opa[5] = in_data.d[4]; opb[5] = in_data.d[3];
      for (int j = 0; j < 6; j++) begin
         pp4_in[j][0] = pp_type'(hi_part(opa[j])) * pp_type'(hi_part(opb[j]));
         pp4_in[j][1] = pp_type'(hi_part(opa[j])) * pp_type'(lo_part(opb[j]));
         pp4_in[j][2] = pp_type'(lo_part(opa[j])) * pp_type'(hi_part(opb[j]));
         pp4_in[j][3] = pp_type'(lo_part(opa[j])) * pp_type'(lo_part(opb[j]));
      end
   end

   always_comb begin
      for (int j = 0; j < 6; j++) begin
         prod5_in[j] = (vol_type'($signed(pp4_ff[j][0])) <<< DOT_W)
                     + ((vol_type'($signed(pp4_ff[j][1])) + vol_type'($signed(pp4_ff[j][2])))
                        <<< HALF_W)
                     + vol_type'($signed(pp4_ff[j][3]));
      end
   end

   always_comb begin
      vc6_in = $signed(prod5_ff[0]) - $signed(prod5_ff[1]);
      vb6_in = $signed(prod5_ff[2]) - $signed(prod5_ff[3]);
      va6_in = $signed(prod5_ff[4]) - $signed(prod5_ff[5]);
   end

   always_comb begin
      dot_val_type d1, d2, d3, d4, d5, d6;
      ed_type      f;
      d1 = dot6_ff.d[0];
      d2 = dot6_ff.d[1];
      d3 = dot6_ff.d[2];
      d4 = dot6_ff.d[3];
      d5 = dot6_ff.d[4];
      d6 = dot6_ff.d[5];
      e7_in   = ed_type'(d4) - ed_type'(d3);
      f       = ed_type'(d5) - ed_type'(d6);
      dab7_in = ed_type'(d1) - ed_type'(d3);
      dac7_in = ed_type'(d2) - ed_type'(d6);
      dbc7_in = e7_in + f;
      den7_in = va6_ff + vb6_ff + vc6_ff;
      hit7_in[0] = (d1 <= 0) && (d2 <= 0);
      hit7_in[1] = (d3 >= 0) && (e7_in <= 0);
      hit7_in[2] = (vc6_ff <= 0) && (d1 >= 0) && (d3 <= 0);
      hit7_in[3] = (d6 >= 0) && (f <= 0);
      hit7_in[4] = (vb6_ff <= 0) && (d2 >= 0) && (d6 <= 0);
      hit7_in[5] = (va6_ff <= 0) && (e7_in >= 0) && (f >= 0);
   end

   // first passing test wins; the face is the fallback
   always_comb begin
      sel8_in.start  = geo7_ff.a;
      sel8_in.x1     = geo7_ff.ab;
      sel8_in.x2     = geo7_ff.ac;
      sel8_in.m1     = vb7_ff;
      sel8_in.m2     = vc7_ff;
      sel8_in.den    = den7_ff;
      sel8_in.div_en = (den7_ff != '0);
      sel8_in.region = REG_FACE;
      sel8_in.degen  = (den7_ff == '0);
      if (hit7_ff[0]) begin
         sel8_in.region = REG_VERT_A;
         sel8_in.div_en = 1'b0;
         sel8_in.degen  = 1'b0;
      end else if (hit7_ff[1]) begin
         sel8_in.region = REG_VERT_B;
         sel8_in.start  = geo7_ff.b;
         sel8_in.div_en = 1'b0;
         sel8_in.degen  = 1'b0;
      end else if (hit7_ff[2]) begin
         sel8_in.region = REG_EDGE_AB;
         sel8_in.m1     = vol_type'(d1_7_ff);
         sel8_in.x2     = '0;
         sel8_in.m2     = '0;
         sel8_in.den    = vol_type'(dab7_ff);
         sel8_in.div_en = (dab7_ff != '0);
         sel8_in.degen  = 1'b0;
      end else if (hit7_ff[3]) begin
         sel8_in.region = REG_VERT_C;
         sel8_in.start  = geo7_ff.c;
         sel8_in.div_en = 1'b0;
         sel8_in.degen  = 1'b0;
      end else if (hit7_ff[4]) begin
         sel8_in.region = REG_EDGE_AC;
         sel8_in.x1     = geo7_ff.ac;
         sel8_in.m1     = vol_type'(d2_7_ff);
         sel8_in.x2     = '0;
         sel8_in.m2     = '0;
         sel8_in.den    = vol_type'(dac7_ff);
         sel8_in.div_en = (dac7_ff != '0);
         sel8_in.degen  = 1'b0;
      end else if (hit7_ff[5]) begin
         sel8_in.region = REG_EDGE_BC;
         sel8_in.start  = geo7_ff.b;
         sel8_in.x1     = geo7_ff.bc;
         sel8_in.m1     = vol_type'(e7_ff);
         sel8_in.x2     = '0;
         sel8_in.m2     = '0;
         sel8_in.den    = vol_type'(dbc7_ff);
         sel8_in.div_en = (dbc7_ff != '0);
         sel8_in.degen  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dot4_ff  <= in_data;
         pp4_ff   <= pp4_in;
         dot5_ff  <= dot4_ff;
         prod5_ff <= prod5_in;
         dot6_ff  <= dot5_ff;
         va6_ff   <= va6_in;
         vb6_ff   <= vb6_in;
         vc6_ff   <= vc6_in;
         geo7_ff  <= dot6_ff.geo;
         d1_7_ff  <= dot6_ff.d[0];
         d2_7_ff  <= dot6_ff.d[1];
         e7_ff    <= e7_in;
         dab7_ff  <= dab7_in;
         dac7_ff  <= dac7_in;
         dbc7_ff  <= dbc7_in;
         vb7_ff   <= vb6_ff;
         vc7_ff   <= vc6_ff;
         den7_ff  <= den7_in;
         hit7_ff  <= hit7_in;
         sel8_ff  <= sel8_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   assign out_valid = v8_ff;
   assign out_data  = sel8_ff;

endmodule

/* hdl/cpt_numer.sv */
// ----------------------------------------------------------------------------
// cpt_numer: projection numerators and divider operand magnitudes
// Five stages: chunked products, chunk pair sums, term sums, numerator sum,
// then absolute values and quotient signs.
// ----------------------------------------------------------------------------
module cpt_numer (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  cpt_pkg::sel_type in_data,
   output logic             out_valid,
   output cpt_pkg::div_type out_data
);
   import cpt_pkg::*;

   typedef logic signed [CHUNK_W:0]  chunk_type;
   typedef logic signed [PPN_W-1:0]  ppn_type;
   typedef logic signed [PAIR_W-1:0] pair_type;
   typedef logic signed [NUM_W-1:0]  num_type;

   typedef struct packed {
      coord_type [2:0] start;
      vol_type         den;
      logic            div_en;
      region_type      region;
      logic            degen;
   } side_type;

   side_type                  side_in, side9_ff, side10_ff, side11_ff, side12_ff;
   ppn_type  [2:0][1:0][3:0]  pp9_in, pp9_ff;
   pair_type [2:0][1:0][1:0]  pair10_in, pair10_ff;
   num_type  [2:0][1:0]       term11_in, term11_ff;
   num_type  [2:0]            num12_in, num12_ff;
   div_type                   abs13_in, abs13_ff;
   logic                      v9_ff, v10_ff, v11_ff, v12_ff, v13_ff;

   function automatic chunk_type chunk(input vol_type m, input int c);
      if (c == 3) return chunk_type'($signed(m[VOL_W-1 -: CHUNK_W]));
      return chunk_type'({1'b0, m[c*CHUNK_W +: CHUNK_W]});
   endfunction

   always_comb begin
      side_in.start  = in_data.start;
      side_in.den    = in_data.den;
      side_in.div_en = in_data.div_en;
      side_in.region = in_data.region;
      side_in.degen  = in_data.degen;
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < 4; c++) begin
            pp9_in[k][0][c] = ppn_type'($signed(in_data.x1[k]))
                            * ppn_type'(chunk(in_data.m1, c));
            pp9_in[k][1][c] = ppn_type'($signed(in_data.x2[k]))
                            * ppn_type'(chunk(in_data.m2, c));
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int t = 0; t < 2; t++) begin
            pair10_in[k][t][0] = pair_type'($signed(pp9_ff[k][t][0]))
                               + (pair_type'($signed(pp9_ff[k][t][1])) <<< CHUNK_W);
            pair10_in[k][t][1] = pair_type'($signed(pp9_ff[k][t][2]))
                               + (pair_type'($signed(pp9_ff[k][t][3])) <<< CHUNK_W);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int t = 0; t < 2; t++) begin
            term11_in[k][t] = num_type'($signed(pair10_ff[k][t][0]))
                            + (num_type'($signed(pair10_ff[k][t][1])) <<< (2 * CHUNK_W));
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num12_in[k] = $signed(term11_ff[k][0]) + $signed(term11_ff[k][1]);
      end
   end

   always_comb begin
      num_type          n;
      logic [NUM_W-1:0] un;
      logic             den_neg;
      den_neg         = side12_ff.den[VOL_W-1];
      abs13_in.ud     = den_neg ? VOL_W'(-side12_ff.den) : side12_ff.den;
      abs13_in.quo    = '0;
      abs13_in.ovf    = '0;
      abs13_in.start  = side12_ff.start;
      abs13_in.div_en = side12_ff.div_en;
      abs13_in.region = side12_ff.region;
      abs13_in.degen  = side12_ff.degen;
      for (int k = 0; k < 3; k++) begin
         n               = num12_ff[k];
         un              = (n < 0) ? NUM_W'(-n) : NUM_W'(n);
         abs13_in.rem[k] = REM_W'(un);
         abs13_in.neg[k] = n[NUM_W-1] ^ den_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side9_ff  <= side_in;
         pp9_ff    <= pp9_in;
         side10_ff <= side9_ff;
         pair10_ff <= pair10_in;
         side11_ff <= side10_ff;
         term11_ff <= term11_in;
         side12_ff <= side11_ff;
         num12_ff  <= num12_in;
         abs13_ff  <= abs13_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
      end else if (en) begin
         v9_ff  <= in_valid;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
         v13_ff <= v12_ff;
      end
   end

   assign out_valid = v13_ff;
   assign out_data  = abs13_ff;

endmodule

/* hdl/cpt_div.sv */
// ----------------------------------------------------------------------------
// cpt_div: pipelined restoring divider, three lanes sharing one divisor
// A range check stage, one quotient bit per stage, then rounding to nearest
// with ties away from zero and the sign. Quotients too large for any
// unsaturated result are clamped to a value that still saturates.
// ----------------------------------------------------------------------------
module cpt_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  cpt_pkg::div_type in_data,
   output logic             out_valid,
   output cpt_pkg::quo_type out_data
);
   import cpt_pkg::*;

   localparam int QM_W = QB + 1;

   div_type     src [QB+2];
   logic [QB+1:0] vld;
   quo_type     rnd_in, rnd_ff;
   logic        rnd_v_ff;

   assign src[0] = in_data;
   assign vld[0] = in_valid;

   for (genvar s = 0; s <= QB; s++) begin : g_stage
      div_type nxt_in, nxt_ff;
      logic    v_ff;

      if (s == 0) begin : g_range
         always_comb begin
            logic [REM_W-1:0] limit;
            limit  = REM_W'(src[s].ud) << QB;
            nxt_in = src[s];
            for (int l = 0; l < 3; l++) begin
               nxt_in.ovf[l] = (src[s].rem[l] >= limit);
            end
         end
      end else begin : g_step
         always_comb begin
            logic [REM_W-1:0] trial;
            trial  = REM_W'(src[s].ud) << (QB - s);
            nxt_in = src[s];
            for (int l = 0; l < 3; l++) begin
               if (src[s].rem[l] >= trial) begin
                  nxt_in.rem[l]          = src[s].rem[l] - trial;
                  nxt_in.quo[l][QB - s]  = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nxt_ff <= nxt_in;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= vld[s];
         end
      end

      assign src[s+1] = nxt_ff;
      assign vld[s+1] = v_ff;
   end

   always_comb begin
      logic [QM_W-1:0] qm;
      logic [QS_W-1:0] qpos;
      logic            rb;
      rnd_in.start  = src[QB+1].start;
      rnd_in.div_en = src[QB+1].div_en;
      rnd_in.region = src[QB+1].region;
      rnd_in.degen  = src[QB+1].degen;
      for (int l = 0; l < 3; l++) begin
         rb   = (REM_W'(src[QB+1].rem[l] << 1) >= REM_W'(src[QB+1].ud));
         qm   = QM_W'(src[QB+1].quo[l]) + QM_W'(rb);
         qpos = src[QB+1].ovf[l] ? (QS_W'(1) << QB) : QS_W'(qm);
         rnd_in.quo[l] = src[QB+1].neg[l] ? (QS_W'(0) - qpos) : qpos;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rnd_ff <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_v_ff <= 1'b0;
      end else if (en) begin
         rnd_v_ff <= vld[QB+1];
      end
   end

   assign out_valid = rnd_v_ff;
   assign out_data  = rnd_ff;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for closest_point_on_triangle
// Drives query transactions with random gaps, predicts the nearest point,
// region and degenerate flag at full integer width, and compares every
// response in order while the response side stalls at random.
// ----------------------------------------------------------------------------
module tb;
   import cpt_pkg::*;

   typedef logic signed [255:0] wide_type;

   localparam int       N_RANDOM  = 1300;
   localparam int       TAIL_ITEMS = 150;
   localparam int       LIMIT     = 300000;
   localparam wide_type SAT_HI    = (1 << (CW - 1)) - 1;
   localparam wide_type SAT_LO    = -SAT_HI - 1;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   req_type pending_q[$];
   rsp_type nearest_q[$];
   int      n_errors = 0;
   int      n_rsp    = 0;
   int      gap_left = 0;
   int      hold_left = 0;
   bit      long_hold_done = 0;
   int      cycles   = 0;

   closest_point_on_triangle DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic wide_type dot3(wide_type x[3], wide_type y[3]);
      return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
   endfunction

   // round to nearest, ties away from zero
   function automatic wide_type div_round(wide_type n, wide_type d);
      logic [255:0] un, ud, qq, rr;
      logic         neg;
      neg = n[255] ^ d[255];
      un  = n[255] ? -n : n;
      ud  = d[255] ? -d : d;
      qq  = un / ud;
      rr  = un % ud;
      if ((rr << 1) >= ud) qq = qq + 1;
      return neg ? -$signed(qq) : $signed(qq);
   endfunction

   function automatic coord_type clamp(wide_type v);
      if (v > SAT_HI) v = SAT_HI;
      if (v < SAT_LO) v = SAT_LO;
      return v[CW-1:0];
   endfunction

   function automatic rsp_type put_point(wide_type s[3], wide_type dir[3], wide_type num,
                                         wide_type den, region_type rg, logic dg);
      rsp_type  r;
      wide_type pt[3];
      for (int k = 0; k < 3; k++)
         pt[k] = (den == 0) ? s[k] : s[k] + div_round(num * dir[k], den);
      r.near_x     = clamp(pt[0]);
      r.near_y     = clamp(pt[1]);
      r.near_z     = clamp(pt[2]);
      r.region     = rg;
      r.degenerate = dg;
      return r;
   endfunction

   function automatic rsp_type nearest_point(req_type q);
      wide_type p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3];
      wide_type pt[3], zero3[3];
      wide_type d1, d2, d3, d4, d5, d6, va, vb, vc, e, f, den;
      rsp_type  r;
      p = '{q.point_x, q.point_y, q.point_z};
      a = '{q.vert_a_x, q.vert_a_y, q.vert_a_z};
      b = '{q.vert_b_x, q.vert_b_y, q.vert_b_z};
      c = '{q.vert_c_x, q.vert_c_y, q.vert_c_z};
      zero3 = '{0, 0, 0};
      for (int k = 0; k < 3; k++) begin
         ab[k] = b[k] - a[k];
         ac[k] = c[k] - a[k];
         ap[k] = p[k] - a[k];
         bp[k] = p[k] - b[k];
         cp[k] = p[k] - c[k];
         bc[k] = c[k] - b[k];
      end
      d1 = dot3(ab, ap);
      d2 = dot3(ac, ap);
      if (d1 <= 0 && d2 <= 0) return put_point(a, zero3, 0, 0, REG_VERT_A, 0);
      d3 = dot3(ab, bp);
      d4 = dot3(ac, bp);
      if (d3 >= 0 && d4 <= d3) return put_point(b, zero3, 0, 0, REG_VERT_B, 0);
      vc = d1 * d4 - d3 * d2;
      if (vc <= 0 && d1 >= 0 && d3 <= 0)
         return put_point(a, ab, d1, d1 - d3, REG_EDGE_AB, 0);
      d5 = dot3(ab, cp);
      d6 = dot3(ac, cp);
      if (d6 >= 0 && d5 <= d6) return put_point(c, zero3, 0, 0, REG_VERT_C, 0);
      vb = d5 * d2 - d1 * d6;
      if (vb <= 0 && d2 >= 0 && d6 <= 0)
         return put_point(a, ac, d2, d2 - d6, REG_EDGE_AC, 0);
      va = d3 * d6 - d5 * d4;
      e  = d4 - d3;
      f  = d5 - d6;
      if (va <= 0 && e >= 0 && f >= 0) return put_point(b, bc, e, e + f, REG_EDGE_BC, 0);
      den = va + vb + vc;
      if (den == 0) return put_point(a, zero3, 0, 0, REG_FACE, 1);
      for (int k = 0; k < 3; k++) pt[k] = a[k] + div_round(ab[k] * vb + ac[k] * vc, den);
      r.near_x     = clamp(pt[0]);
      r.near_y     = clamp(pt[1]);
      r.near_z     = clamp(pt[2]);
      r.region     = REG_FACE;
      r.degenerate = 0;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic req_type make_query(int px, int py, int pz, int ax, int ay, int az,
                                          int bx, int by, int bz, int cx, int cy, int cz);
      return '{px[CW-1:0], py[CW-1:0], pz[CW-1:0], ax[CW-1:0], ay[CW-1:0], az[CW-1:0],
               bx[CW-1:0], by[CW-1:0], bz[CW-1:0], cx[CW-1:0], cy[CW-1:0], cz[CW-1:0]};
   endfunction

   function automatic int rnd_val(int bits);
      logic [31:0] u;
      u = $urandom;
      return $signed(u) >>> (32 - bits);
   endfunction

   function automatic req_type random_query();
      req_type   q;
      int        mode, bits, k;
      coord_type ox, oy, oz;
      logic [CW*12-1:0] flat;
      mode = $urandom_range(0, 9);
      bits = (mode == 5) ? CW : $urandom_range(4, 16);
      for (int i = 0; i < 12; i++) flat[i*CW +: CW] = CW'(rnd_val(bits));
      q = flat;
      case (mode)
         6: begin   // shared vertex or collinear triangle
            k = $urandom_range(0, 3);
            q.vert_b_x = q.vert_a_x + (q.vert_b_x >>> 4);
            q.vert_b_y = q.vert_a_y + (q.vert_b_y >>> 4);
            q.vert_b_z = q.vert_a_z + (q.vert_b_z >>> 4);
            if (k == 0) begin
               q.vert_b_x = q.vert_a_x; q.vert_b_y = q.vert_a_y; q.vert_b_z = q.vert_a_z;
            end
            q.vert_c_x = coord_type'(q.vert_a_x + k * (q.vert_b_x - q.vert_a_x));
            q.vert_c_y = coord_type'(q.vert_a_y + k * (q.vert_b_y - q.vert_a_y));
            q.vert_c_z = coord_type'(q.vert_a_z + k * (q.vert_b_z - q.vert_a_z));
         end
         7: begin   // far query point, small triangle
            q.point_x = coord_type'(rnd_val(CW));
            q.point_y = coord_type'(rnd_val(CW));
            q.point_z = coord_type'(rnd_val(CW));
         end
         8: begin   // small triangle pushed near an end of the x range
            ox = coord_type'($urandom_range(0, 1) ? (1 << (CW - 1)) - 70000
                                                  : -(1 << (CW - 1)) + 70000);
            oy = coord_type'(rnd_val(CW));
            oz = coord_type'(rnd_val(CW));
            q.point_x += ox; q.vert_a_x += ox; q.vert_b_x += ox; q.vert_c_x += ox;
            q.point_y += oy; q.vert_a_y += oy; q.vert_b_y += oy; q.vert_c_y += oy;
            q.point_z += oz; q.vert_a_z += oz; q.vert_b_z += oz; q.vert_c_z += oz;
         end
         default: ;
      endcase
      return q;
   endfunction

   initial begin
      int mx, mn;
      mx = (1 << (CW - 1)) - 1;
      mn = -(1 << (CW - 1));
      reset     = 1;
      req_valid = 0;
      req_data  = '0;
      rsp_ready = 0;
      // one per region on a right triangle in the z = 0 plane
      pending_q.push_back(make_query(-100, -100, 5, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
      pending_q.push_back(make_query(20000, -10, 0, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
      pending_q.push_back(make_query(8000, -500, 300, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
      pending_q.push_back(make_query(-10, 20000, 0, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
      pending_q.push_back(make_query(-500, 8000, 0, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
      pending_q.push_back(make_query(10000, 10000, 0, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
      pending_q.push_back(make_query(3000, 3000, 7777, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
      pending_q.push_back(make_query(3001, 2999, -7, 5, 3, 1, 16383, 7, -2, 9, 16381, 3));
      // zero-length edges
      pending_q.push_back(make_query(5000, 3000, 0, 0, 0, 0, 0, 0, 0, 0, 16384, 0));
      pending_q.push_back(make_query(3000, 5000, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0));
      pending_q.push_back(make_query(-9000, 7000, 1, 0, 0, 0, 16384, 0, 0, 16384, 0, 0));
      // collinear and point triangles
      pending_q.push_back(make_query(6000, 5000, 0, 0, 0, 0, 4096, 0, 0, 8192, 0, 0));
      pending_q.push_back(make_query(2000, 0, 0, 0, 0, 0, 4096, 0, 0, 8192, 0, 0));
      pending_q.push_back(make_query(4096, 300, 0, 0, 0, 0, 8192, 0, 0, 4096, 0, 0));
      pending_q.push_back(make_query(77, -88, 99, 5, 5, 5, 5, 5, 5, 5, 5, 5));
      // field extremes
      pending_q.push_back(make_query(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
      pending_q.push_back(make_query(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
      pending_q.push_back(make_query(mx, mn, mx, mn, mn, mn, mx, mn, mn, mn, mx, mx));
      pending_q.push_back(make_query(0, 0, 0, mn, mn, 0, mx, mn, 0, 0, mx, 0));
      pending_q.push_back(make_query(mx, mx, mn, mn, mx, mn, mx, mn, mx, mx, mx, mn));
      pending_q.push_back(make_query(0, 0, mx, mx, mn, 0, mn, mx, 0, mx, mx, 0));
      pending_q.push_back(make_query(-1, 1, -1, mx, 0, 0, 0, mx, 0, 0, 0, mx));
      for (int i = 0; i < N_RANDOM; i++) pending_q.push_back(random_query());

      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (pending_q.size() != 0 || req_valid) @(posedge clock);
      while (nearest_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (n_errors == 0 && nearest_q.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) nearest_q.push_back(nearest_point(req_data));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 0;
            end else if (pending_q.size() != 0) begin
               req_data  <= pending_q.pop_front();
               req_valid <= 1;
               if (pending_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
                  gap_left <= $urandom_range(1, 3);
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   task automatic check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         n_errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (nearest_q.size() == 0) begin
               $display("%0t: response with none expected, actual %0h", $time, rsp_data);
               n_errors++;
            end else begin
               want = nearest_q.pop_front();
               check_field("near_x", want.near_x, rsp_data.near_x);
               check_field("near_y", want.near_y, rsp_data.near_y);
               check_field("near_z", want.near_z, rsp_data.near_z);
               check_field("region", want.region, rsp_data.region);
               check_field("degenerate", want.degenerate, rsp_data.degenerate);
            end
            n_rsp++;
         end
         // hold off once long enough to fill the pipeline and stall requests
         if (!long_hold_done && n_rsp >= 300) begin
            long_hold_done <= 1;
            hold_left      <= 200;
            rsp_ready      <= 0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 0;
         end else if (pending_q.size() <= TAIL_ITEMS) begin
            rsp_ready <= 1;
         end else if ($urandom_range(0, 5) == 0) begin
            hold_left <= $urandom_range(0, 2);
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

endmodule
